// ===== rtl/core/lmr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and codes for the lossy message ring.
// Used by every module of the block but lmr_ram; depends on nothing.
package lmr_pkg;

   localparam int SLOT_COUNT  = 16;
   localparam int SLOT_WORDS  = 8;
   localparam int TIME_BITS   = 48;
   localparam int QUEUE_DEPTH = 4;

   localparam int LOG2_MAX    = $clog2(SLOT_COUNT + 1) - 1;
   localparam int SLOT_W      = $clog2(SLOT_COUNT);
   localparam int PHYS_COUNT  = SLOT_COUNT + 1;
   localparam int PHYS_W      = $clog2(PHYS_COUNT);
   localparam int WCNT_W      = $clog2(SLOT_WORDS + 1);
   localparam int RAM_DEPTH   = PHYS_COUNT * SLOT_WORDS;
   localparam int RAM_AW      = $clog2(RAM_DEPTH);
   localparam int CAP_BYTES   = 8 * SLOT_WORDS;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0]  SLOT_LOG2_RESET = 3'd4;
   localparam logic [6:0]  MAX_BYTES_RESET = 7'd64;
   localparam logic [31:0] TIMEOUT_RESET   = 32'd250000000;

   localparam logic [1:0] CSR_SLOT_LOG2 = 2'd0;
   localparam logic [1:0] CSR_MAX_BYTES = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd2;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_TOO_LARGE = 3'd2,
      ST_BAD_LEN   = 3'd3,
      ST_SHORT     = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]  slot_log2;
      logic [6:0]  max_bytes;
      logic [31:0] timeout;
   } cfg_type;

   typedef struct packed {
      status_type          status;
      logic [6:0]          bytes;
      logic [31:0]         pend;
      logic [PHYS_W-1:0]   phys;
      logic [WCNT_W-1:0]   nwords;
      logic [WCNT_W-1:0]   have;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] word;
      logic [6:0]  bytes;
      logic [31:0] pend;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic              en;
      logic [RAM_AW-1:0] addr;
      logic [63:0]       data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [RAM_AW-1:0] addr;
   } ram_rd_type;

endpackage

// ===== rtl/core/lmr_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module lmr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 136
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/lmr_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and back parts of the ring.
// Depends on lmr_pkg.
module lmr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lmr_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output lmr_pkg::cmd_type head
);
   import lmr_pkg::*;

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      full      = count_ff == QCNT_W'(QUEUE_DEPTH);
      valid     = count_ff != '0;
      head      = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_ff + 1'b1);
      end
      count_in = QCNT_W'(count_ff + QCNT_W'(push) - QCNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

// ===== rtl/core/lmr_front.sv =====
`timescale 1ns / 1ps
// Front part: accepts items, fills the spare buffer, commits messages and
// decides each read; pushes one command per result-bearing item. Uses lmr_pkg.
module lmr_front (
   input  logic                clock,
   input  logic                reset,
   input  lmr_pkg::cfg_type    cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [63:0]         req_data_word,
   input  logic                req_last_word,
   input  logic [9:0]          req_byte_count,
   input  logic [47:0]         req_time_now,
   output logic                q_push,
   output lmr_pkg::cmd_type    q_cmd,
   input  logic                q_full,
   input  logic                buf_release,
   output lmr_pkg::ram_wr_type ram_wr
);
   import lmr_pkg::*;

   logic [31:0]          wr_idx_ff, wr_idx_in, rd_idx_ff, rd_idx_in;
   logic [TIME_BITS-1:0] commit_time_ff, commit_time_in, read_time_ff, read_time_in;
   logic [WCNT_W-1:0]    fill_pos_ff, fill_pos_in;
   logic                 fill_ovf_ff, fill_ovf_in;
   logic [PHYS_W-1:0]    spare_ff, spare_in;
   logic [QCNT_W-1:0]    read_cnt_ff, read_cnt_in;
   logic [PHYS_W-1:0]    map_ff [SLOT_COUNT];
   logic [6:0]           len_ff [SLOT_COUNT];
   logic [WCNT_W-1:0]    have_ff [SLOT_COUNT];

   logic                 accept, is_write, pos_ok, ovf_now, wr_ok, commit;
   logic                 stale, caught_up;
   logic [WCNT_W-1:0]    pos_next, len_words, slot_have;
   logic [3:0]           eff_log2;
   logic [31:0]          ring_mask, ring_half, lag, rd_sel;
   logic [9:0]           max_bytes;
   logic [TIME_BITS-1:0] now, delta;
   logic [SLOT_W-1:0]    slot;
   logic [PHYS_W-1:0]    slot_phys;
   logic [6:0]           slot_len;

   always_comb begin
      is_write  = req_opcode == OP_WRITE;
      req_stall = q_full || (is_write && read_cnt_ff != '0);
      accept    = req_valid && !req_stall;
      now       = TIME_BITS'(req_time_now);
      eff_log2  = (4'(cfg.slot_log2) < 4'(LOG2_MAX)) ? 4'(cfg.slot_log2) : 4'(LOG2_MAX);
      ring_mask = (32'd1 << eff_log2) - 32'd1;
      ring_half = (32'd1 << eff_log2) >> 1;
      max_bytes = (10'(cfg.max_bytes) < 10'(CAP_BYTES)) ? 10'(cfg.max_bytes) : 10'(CAP_BYTES);
      caught_up = rd_idx_ff == wr_idx_ff;
      lag       = wr_idx_ff - rd_idx_ff;
      delta     = commit_time_ff - read_time_ff;
      stale     = !delta[TIME_BITS-1] && (delta > TIME_BITS'(cfg.timeout));
      rd_sel    = (lag > ring_half || stale) ? wr_idx_ff - 32'd1 : rd_idx_ff;
      slot      = SLOT_W'((is_write ? wr_idx_ff : rd_sel) & ring_mask);
      slot_phys = map_ff[slot];
      slot_len  = len_ff[slot];
      slot_have = have_ff[slot];
      len_words = WCNT_W'({1'b0, slot_len[6:3]} + 5'(|slot_len[2:0]));
      pos_ok    = fill_pos_ff < WCNT_W'(SLOT_WORDS);
      pos_next  = pos_ok ? WCNT_W'(fill_pos_ff + 1'b1) : fill_pos_ff;
      ovf_now   = fill_ovf_ff || !pos_ok;
      wr_ok     = !ovf_now && (req_byte_count <= max_bytes);
      commit    = accept && is_write && req_last_word && wr_ok;
   end

   always_comb begin
      ram_wr.en   = accept && is_write && pos_ok;
      ram_wr.addr = RAM_AW'(RAM_AW'(spare_ff) * RAM_AW'(SLOT_WORDS) + RAM_AW'(fill_pos_ff));
      ram_wr.data = req_data_word;
   end

   always_comb begin
      q_push       = accept && (!is_write || req_last_word);
      q_cmd.status = ST_OK;
      q_cmd.bytes  = '0;
      q_cmd.pend   = '0;
      q_cmd.phys   = slot_phys;
      q_cmd.nwords = '0;
      q_cmd.have   = slot_have;
      priority if (is_write) begin
         if (wr_ok) begin
            q_cmd.bytes = req_byte_count[6:0];
         end else begin
            q_cmd.status = ST_TOO_LARGE;
         end
      end else if (caught_up) begin
         q_cmd.status = ST_EMPTY;
      end else begin
         q_cmd.pend = wr_idx_ff - rd_sel - 32'd1;
         priority if (10'(slot_len) > max_bytes) begin
            q_cmd.status = ST_BAD_LEN;
         end else if (req_byte_count < 10'(slot_len)) begin
            q_cmd.status = ST_SHORT;
            q_cmd.bytes  = slot_len;
         end else begin
            q_cmd.bytes  = slot_len;
            q_cmd.nwords = len_words;
         end
      end
   end

   always_comb begin
      wr_idx_in      = wr_idx_ff;
      rd_idx_in      = rd_idx_ff;
      commit_time_in = commit_time_ff;
      read_time_in   = read_time_ff;
      fill_pos_in    = fill_pos_ff;
      fill_ovf_in    = fill_ovf_ff;
      spare_in       = spare_ff;
      if (accept) begin
         if (is_write) begin
            fill_pos_in = pos_next;
            fill_ovf_in = ovf_now;
            if (req_last_word) begin
               fill_pos_in = '0;
               fill_ovf_in = 1'b0;
            end
            if (commit) begin
               wr_idx_in      = wr_idx_ff + 32'd1;
               commit_time_in = now;
               spare_in       = slot_phys;
            end
         end else begin
            read_time_in = now;
            if (!caught_up) begin
               rd_idx_in = rd_sel + 32'd1;
            end
         end
      end
      read_cnt_in = QCNT_W'(read_cnt_ff + QCNT_W'(q_push && q_cmd.nwords != '0)
                            - QCNT_W'(buf_release));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff      <= '0;
         rd_idx_ff      <= '0;
         commit_time_ff <= '0;
         read_time_ff   <= '0;
         fill_pos_ff    <= '0;
         fill_ovf_ff    <= 1'b0;
         spare_ff       <= PHYS_W'(SLOT_COUNT);
         read_cnt_ff    <= '0;
      end else begin
         wr_idx_ff      <= wr_idx_in;
         rd_idx_ff      <= rd_idx_in;
         commit_time_ff <= commit_time_in;
         read_time_ff   <= read_time_in;
         fill_pos_ff    <= fill_pos_in;
         fill_ovf_ff    <= fill_ovf_in;
         spare_ff       <= spare_in;
         read_cnt_ff    <= read_cnt_in;
      end
   end

   // slot to buffer map starts as identity, buffer SLOT_COUNT is the spare
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            map_ff[i] <= PHYS_W'(i);
         end
      end else if (commit) begin
         map_ff[slot] <= spare_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         len_ff[slot]  <= req_byte_count[6:0];
         have_ff[slot] <= pos_next;
      end
   end

   a_read_cnt_range: assert property (@(posedge clock) disable iff (reset)
      read_cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("outstanding read count above queue depth");

   a_release_counted: assert property (@(posedge clock) disable iff (reset)
      buf_release |-> read_cnt_ff != '0)
      else $error("buffer released with no read outstanding");

   a_commit_swap: assert property (@(posedge clock) disable iff (reset)
      commit |=> (map_ff[$past(slot)] == $past(spare_ff)) && (spare_ff != $past(spare_ff)))
      else $error("commit did not swap spare buffer into slot");
endmodule

// ===== rtl/core/lmr_back.sv =====
`timescale 1ns / 1ps
// Back part: walks queued commands, reads payload words from the RAM and
// delivers result items through a two-entry output buffer. Uses lmr_pkg.
module lmr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  lmr_pkg::cmd_type    q_head,
   output logic                q_pop,
   output lmr_pkg::ram_rd_type ram_rd,
   input  logic [63:0]         ram_rd_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic [63:0]         rsp_out_word,
   output logic [6:0]          rsp_out_bytes,
   output logic [31:0]         rsp_pending,
   output logic                rsp_last_result
);
   import lmr_pkg::*;

   logic [WCNT_W-1:0] idx_ff, idx_in;
   logic              infl_ff;
   logic [1:0]        occ_ff, occ_in;
   rsp_item_type      meta_ff, meta_in, head_ff, head_in, skid_ff, skid_in, arriving;
   logic              keep_ff, keep_in;
   logic [2:0]        part_ff, part_in;
   logic              pop, issue, last_issue, space_ok;
   logic [63:0]       masked;

   always_comb begin
      pop        = rsp_valid && !rsp_stall;
      space_ok   = (3'(occ_ff) + 3'(infl_ff)) <= (3'd1 + 3'(pop));
      issue      = q_valid && space_ok;
      last_issue = (q_head.nwords == '0) || (idx_ff == WCNT_W'(q_head.nwords - 1'b1));
      q_pop      = issue && last_issue;
      idx_in     = idx_ff;
      if (issue) begin
         idx_in = last_issue ? '0 : WCNT_W'(idx_ff + 1'b1);
      end
      ram_rd.en   = issue && q_head.nwords != '0;
      ram_rd.addr = RAM_AW'(RAM_AW'(q_head.phys) * RAM_AW'(SLOT_WORDS) + RAM_AW'(idx_ff));

      meta_in.status = q_head.status;
      meta_in.word   = '0;
      meta_in.bytes  = q_head.bytes;
      meta_in.pend   = q_head.pend;
      meta_in.last   = last_issue;
      // words past the stored count were never sent and read as zero
      keep_in = (q_head.nwords != '0) && (idx_ff < q_head.have);
      part_in = last_issue ? q_head.bytes[2:0] : 3'd0;
   end

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         masked[8*b +: 8] = (part_ff == 3'd0 || 3'(b) < part_ff) ? ram_rd_data[8*b +: 8] : 8'd0;
      end
      arriving      = meta_ff;
      arriving.word = keep_ff ? masked : '0;
   end

   always_comb begin
      head_in = head_ff;
      skid_in = skid_ff;
      priority if (pop && occ_ff == 2'd2) begin
         head_in = skid_ff;
         if (infl_ff) begin
            skid_in = arriving;
         end
      end else if (infl_ff && (occ_ff == 2'd0 || (pop && occ_ff == 2'd1))) begin
         head_in = arriving;
      end else if (infl_ff && occ_ff == 2'd1) begin
         skid_in = arriving;
      end else begin
         head_in = head_ff;
      end
      occ_in = 2'(occ_ff + 2'(infl_ff) - 2'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         infl_ff <= 1'b0;
         occ_ff  <= '0;
      end else begin
         idx_ff  <= idx_in;
         infl_ff <= issue;
         occ_ff  <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         meta_ff <= meta_in;
         keep_ff <= keep_in;
         part_ff <= part_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = occ_ff != 2'd0;
   assign rsp_status      = head_ff.status;
   assign rsp_out_word    = head_ff.word;
   assign rsp_out_bytes   = head_ff.bytes;
   assign rsp_pending     = head_ff.pend;
   assign rsp_last_result = head_ff.last;

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff != 2'd3)
      else $error("output buffer over capacity");

   a_arrival_room: assert property (@(posedge clock) disable iff (reset)
      infl_ff && occ_ff == 2'd2 |-> pop)
      else $error("item arrived with output buffer full");
endmodule

// ===== rtl/core/lossy_message_ring.sv =====
`timescale 1ns / 1ps
// Lossy message ring, top level. Write words are taken one per cycle unless
// stalled, as are the payload words that follow a read result.
// Write words wait while a read that returns payload is still queued.
// Reset (synchronous) clears indexes, times, fill state, queue and config;
// message storage is not cleared. Depends on lmr_pkg and the lmr_* modules.
module lossy_message_ring (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [63:0] req_data_word,
   input  logic        req_last_word,
   input  logic [9:0]  req_byte_count,
   input  logic [47:0] req_time_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_out_word,
   output logic [6:0]  rsp_out_bytes,
   output logic [31:0] rsp_pending,
   output logic        rsp_last_result
);
   import lmr_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        q_push, q_full, q_pop, q_valid, buf_release;
   cmd_type     q_cmd, q_head;
   ram_wr_type  ram_wr;
   ram_rd_type  ram_rd;
   logic [63:0] ram_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SLOT_LOG2: cfg_in.slot_log2 = csr_data[2:0];
            CSR_MAX_BYTES: cfg_in.max_bytes = csr_data[6:0];
            CSR_TIMEOUT:   cfg_in.timeout   = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_log2 <= SLOT_LOG2_RESET;
         cfg_ff.max_bytes <= MAX_BYTES_RESET;
         cfg_ff.timeout   <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign buf_release = q_pop && q_head.nwords != '0;

   lmr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_data_word  (req_data_word),
      .req_last_word  (req_last_word),
      .req_byte_count (req_byte_count),
      .req_time_now   (req_time_now),
      .q_push         (q_push),
      .q_cmd          (q_cmd),
      .q_full         (q_full),
      .buf_release    (buf_release),
      .ram_wr         (ram_wr)
   );

   lmr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   lmr_ram #(
      .WIDTH (64),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (ram_rd_data)
   );

   lmr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .ram_rd          (ram_rd),
      .ram_rd_data     (ram_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_word    (rsp_out_word),
      .rsp_out_bytes   (rsp_out_bytes),
      .rsp_pending     (rsp_pending),
      .rsp_last_result (rsp_last_result)
   );
endmodule
